### sv/sc1a_pkg.sv
// Types, constants and key tables shared by the scancode set 1 translator.
package sc1a_pkg;

  typedef enum logic [1:0] {
    KIND_CHAR   = 2'd0,
    KIND_LED    = 2'd1,
    KIND_REBOOT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PFX_NONE = 2'd0,
    PFX_E0   = 2'd1,
    PFX_E1   = 2'd2
  } prefix_t;

  localparam int unsigned MaxRes = 4;

  typedef struct packed {
    logic [2:0]             cnt;
    kind_t [MaxRes-1:0]     kind;
    logic [MaxRes-1:0][7:0] data;
  } res_t;

  localparam logic [7:0] SC_E0 = 8'he0;
  localparam logic [7:0] SC_E1 = 8'he1;

  localparam logic [6:0] SC_CTRL     = 7'h1d;
  localparam logic [6:0] SC_ALT      = 7'h38;
  localparam logic [6:0] SC_LSHIFT   = 7'h2a;
  localparam logic [6:0] SC_RSHIFT   = 7'h36;
  localparam logic [6:0] SC_CAPS     = 7'h3a;
  localparam logic [6:0] SC_NUM      = 7'h45;
  localparam logic [6:0] SC_SCROLL   = 7'h46;
  localparam logic [6:0] SC_F1       = 7'h3b;
  localparam logic [6:0] SC_F10      = 7'h44;
  localparam logic [6:0] SC_SLASH    = 7'h35;
  localparam logic [6:0] SC_PAD_STAR = 7'h37;
  localparam logic [6:0] SC_PAD_HOME = 7'h47;
  localparam logic [6:0] SC_PAD_DEL  = 7'h53;
  localparam logic [6:0] SC_UNKNOWN  = 7'h54;

  localparam int unsigned LockScroll = 0;
  localparam int unsigned LockNum    = 1;
  localparam int unsigned LockCaps   = 2;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_QUEST = 8'h3f;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPZ   = 8'h5a;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOZ   = 8'h7a;
  localparam logic [7:0] CH_AT    = 8'h40;
  localparam logic [7:0] CH_DEL_FOLD_END = 8'h60;
  localparam logic [7:0] CASE_BIT = 8'h20;
  localparam logic [7:0] CTRL_SUB = 8'h40;
  localparam logic [7:0] META_BIT = 8'h80;

  localparam logic [7:0] KEYMAP_PLAIN [0:63] = '{
    8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
    8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] KEYMAP_SHIFT [0:63] = '{
    8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
    8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
    8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] KEYMAP_ALTGR [0:63] = '{
    8'h00, 8'h00, 8'h00, 8'h40, 8'h00, 8'h24, 8'h00, 8'h00,
    8'h7b, 8'h5b, 8'h5d, 8'h7d, 8'h5c, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h7e, 8'h0d, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // bit 7 marks the ESC [ x ~ form
  localparam logic [7:0] PAD_CURSOR [0:15] = '{
    8'h48, 8'h41, 8'hb5, 8'h2d, 8'h44, 8'h35, 8'h43, 8'h2b,
    8'hb4, 8'h42, 8'hb6, 8'hb2, 8'h7f, 8'h00, 8'h00, 8'h00
  };

  localparam logic [7:0] PAD_NUMBER [0:15] = '{
    8'h37, 8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h2e, 8'h00, 8'h00, 8'h00
  };

endpackage

### sv/sc1a_xlate.sv
// Modifier, lock and prefix state plus translation of one scancode into results.
module sc1a_xlate
  import sc1a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic [7:0] code,
  input  logic [2:0] room,
  output res_t       res
);

  prefix_t    prefix_r, prefix_nxt;
  logic       lctrl_r, lctrl_nxt;
  logic       rctrl_r, rctrl_nxt;
  logic       lshift_r, lshift_nxt;
  logic       rshift_r, rshift_nxt;
  logic       lalt_r, lalt_nxt;
  logic       ralt_r, ralt_nxt;
  logic [2:0] lock_r, lock_nxt;

  logic [6:0] bare;
  logic       press;
  logic       ctl;
  logic       alt;
  logic       shift;
  logic       room_ge1;
  logic       room_ge3;
  logic       room_ge4;
  logic [5:0] map_idx;
  logic [3:0] pad_idx;
  logic [6:0] pad_off;
  logic [7:0] map_ch;
  logic [7:0] ch;
  logic [7:0] cur;
  logic       cursor_mode;

  assign bare     = code[6:0];
  assign press    = ~code[7];
  assign ctl      = lctrl_r | rctrl_r;
  assign alt      = lalt_r | ralt_r;
  assign shift    = lshift_r | rshift_r;
  assign room_ge1 = |room;
  assign room_ge3 = room[2] | (room[1] & room[0]);
  assign room_ge4 = room[2];
  assign map_idx  = bare[5:0];
  assign pad_off  = bare - SC_PAD_HOME;
  assign pad_idx  = pad_off[3:0];
  assign cur      = PAD_CURSOR[pad_idx];
  assign cursor_mode = (prefix_r == PFX_E0) | ~lock_r[LockNum] | shift;

  always_comb begin
    priority if (ralt_r) begin
      map_ch = KEYMAP_ALTGR[map_idx];
    end else if (shift) begin
      map_ch = KEYMAP_SHIFT[map_idx];
    end else begin
      map_ch = KEYMAP_PLAIN[map_idx];
    end
  end

  always_comb begin
    ch = map_ch;
    if (!(shift && !ralt_r) && (lock_r[LockCaps] || ctl) && ch >= CH_LOA && ch <= CH_LOZ) begin
      ch = ch - CASE_BIT;
    end
    if (ctl) begin
      if (ch >= CH_AT && ch < CH_DEL_FOLD_END) begin
        ch = ch - CTRL_SUB;
      end else if (ch == CH_QUEST) begin
        ch = CH_DEL;
      end
    end
    if (lalt_r) begin
      ch = ch | META_BIT;
    end
  end

  always_comb begin
    res        = '0;
    prefix_nxt = PFX_NONE;
    lctrl_nxt  = lctrl_r;
    rctrl_nxt  = rctrl_r;
    lshift_nxt = lshift_r;
    rshift_nxt = rshift_r;
    lalt_nxt   = lalt_r;
    ralt_nxt   = ralt_r;
    lock_nxt   = lock_r;
    priority if (code == SC_E0) begin
      prefix_nxt = PFX_E0;
    end else if (code == SC_E1) begin
      prefix_nxt = PFX_E1;
    end else if (bare == SC_CTRL) begin
      if (prefix_r != PFX_NONE) begin
        rctrl_nxt = press;
      end else begin
        lctrl_nxt = press;
      end
    end else if (bare == SC_ALT) begin
      if (prefix_r != PFX_NONE) begin
        ralt_nxt = press;
      end else begin
        lalt_nxt = press;
      end
    end else if (bare == SC_LSHIFT) begin
      lshift_nxt = press;
    end else if (bare == SC_RSHIFT) begin
      rshift_nxt = press;
    end else if (!press || bare >= SC_UNKNOWN) begin
      res.cnt = 3'd0;
    end else if (bare == SC_CAPS || bare == SC_NUM || bare == SC_SCROLL) begin
      lock_nxt[LockCaps]   = lock_r[LockCaps] ^ (bare == SC_CAPS);
      lock_nxt[LockNum]    = lock_r[LockNum] ^ (bare == SC_NUM);
      lock_nxt[LockScroll] = lock_r[LockScroll] ^ (bare == SC_SCROLL);
      res.cnt     = 3'd1;
      res.kind[0] = KIND_LED;
      res.data[0] = {5'd0, lock_nxt};
    end else if (bare >= SC_F1 && bare <= SC_F10) begin
      if (room_ge4) begin
        res.cnt     = 3'd4;
        res.data[0] = CH_ESC;
        res.data[1] = CH_LBRK;
        res.data[2] = CH_LBRK;
        res.data[3] = {1'b0, bare - SC_F1} + CH_UPA;
      end
    end else if (bare == SC_PAD_STAR || bare >= SC_PAD_HOME) begin
      if (bare == SC_PAD_DEL && ctl && alt) begin
        res.cnt     = 3'd1;
        res.kind[0] = KIND_REBOOT;
      end else if (cursor_mode) begin
        if (bare != SC_PAD_STAR) begin
          if (cur[7]) begin
            if (room_ge4) begin
              res.cnt     = 3'd4;
              res.data[0] = CH_ESC;
              res.data[1] = CH_LBRK;
              res.data[2] = {1'b0, cur[6:0]};
              res.data[3] = CH_TILDE;
            end
          end else if (cur >= CH_UPA && cur <= CH_UPZ) begin
            if (room_ge3) begin
              res.cnt     = 3'd3;
              res.data[0] = CH_ESC;
              res.data[1] = CH_LBRK;
              res.data[2] = cur;
            end
          end else if (room_ge1) begin
            res.cnt     = 3'd1;
            res.data[0] = cur;
          end
        end
      end else if (room_ge1) begin
        res.cnt     = 3'd1;
        res.data[0] = (bare == SC_PAD_STAR) ? CH_STAR : PAD_NUMBER[pad_idx];
      end
    end else if (bare == SC_SLASH && prefix_r == PFX_E0) begin
      if (room_ge1) begin
        res.cnt     = 3'd1;
        res.data[0] = CH_SLASH;
      end
    end else begin
      if (map_ch != 8'h00 && room_ge1) begin
        res.cnt     = 3'd1;
        res.data[0] = ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r <= PFX_NONE;
      lctrl_r  <= 1'b0;
      rctrl_r  <= 1'b0;
      lshift_r <= 1'b0;
      rshift_r <= 1'b0;
      lalt_r   <= 1'b0;
      ralt_r   <= 1'b0;
      lock_r   <= 3'd0;
    end else if (step) begin
      prefix_r <= prefix_nxt;
      lctrl_r  <= lctrl_nxt;
      rctrl_r  <= rctrl_nxt;
      lshift_r <= lshift_nxt;
      rshift_r <= rshift_nxt;
      lalt_r   <= lalt_nxt;
      ralt_r   <= ralt_nxt;
      lock_r   <= lock_nxt;
    end
  end

endmodule

### sv/sc1a_outbuf.sv
// Result register for up to four results of one item; sends one a cycle unless stalled.
module sc1a_outbuf
  import sc1a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  res_t       res,
  input  logic       out_stall,
  output logic       free,
  output logic       out_valid,
  output kind_t      kind,
  output logic [7:0] data,
  output logic       last
);

  logic                   valid_r, valid_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic [1:0]             last_r;
  kind_t [MaxRes-1:0]     kind_r;
  logic [MaxRes-1:0][7:0] data_r;
  logic                   xfer;
  logic                   done;
  logic [2:0]             cnt_m1;

  assign xfer      = valid_r & ~out_stall;
  assign done      = xfer & (idx_r == last_r);
  assign free      = ~valid_r | done;
  assign cnt_m1    = res.cnt - 3'd1;
  assign out_valid = valid_r;
  assign kind      = kind_r[idx_r];
  assign data      = data_r[idx_r];
  assign last      = (idx_r == last_r);

  always_comb begin
    valid_nxt = valid_r;
    idx_nxt   = idx_r;
    priority if (load) begin
      valid_nxt = 1'b1;
      idx_nxt   = 2'd0;
    end else if (done) begin
      valid_nxt = 1'b0;
    end else if (xfer) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= 2'd0;
    end else begin
      valid_r <= valid_nxt;
      idx_r   <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      last_r <= cnt_m1[1:0];
      kind_r <= res.kind;
      data_r <= res.data;
    end
  end

  a_idx_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> idx_r <= last_r)
    else $error("result index beyond last result");

  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free && res.cnt != 3'd0 && res.cnt <= 3'd4)
    else $error("load into busy buffer or with bad count");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    xfer && !done && !load |=> valid_r && idx_r == $past(idx_r) + 2'd1)
    else $error("result sequence did not advance");

endmodule

### sv/scancode_set1_to_ascii.sv
// Top level: input register, translator and result buffer for set-1 scancodes.
//
// Input channel: in_valid/in_stall carry one raw set-1 byte (in_scan_code) and
// the free downstream byte count (in_out_room, 4 or more means 4). An item is
// taken on an edge with in_valid high and in_stall low.
// Result channel: out_valid/out_stall carry out_kind, out_byte and out_last;
// out_last marks the final result of an input byte. An input byte causes zero
// to four results.
// The accepted byte is registered in the input register, translated, and its
// results are loaded into the result buffer, which drives the result channel.
// Throughput: one byte per cycle while bytes cause at most one result and the
// receiver does not stall; a byte with N results holds the result buffer until
// all N have gone, as the port sends one result a cycle unless stalled.
// Reset (rst_n low, synchronous) clears the prefix, all modifier and lock
// flags, and empties the input register and result buffer.
// While the receiver stalls, the current result holds; one further input byte
// is taken into the input register, then in_stall rises.
module scancode_set1_to_ascii
  import sc1a_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_scan_code,
  input  logic [2:0] in_out_room,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last
);

  logic       a_valid_r, a_valid_nxt;
  logic [7:0] a_code_r;
  logic [2:0] a_room_r;
  logic       a_move;
  logic       in_xfer;
  logic       buf_free;
  res_t       res;
  kind_t      kind;

  assign a_move   = a_valid_r & buf_free;
  assign in_stall = a_valid_r & ~a_move;
  assign in_xfer  = in_valid & ~in_stall;
  assign out_kind = kind;

  always_comb begin
    priority if (in_xfer) begin
      a_valid_nxt = 1'b1;
    end else if (a_move) begin
      a_valid_nxt = 1'b0;
    end else begin
      a_valid_nxt = a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      a_code_r <= in_scan_code;
      a_room_r <= in_out_room;
    end
  end

  sc1a_xlate u_xlate (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (a_move),
    .code  (a_code_r),
    .room  (a_room_r),
    .res   (res)
  );

  sc1a_outbuf u_outbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (a_move && res.cnt != 3'd0),
    .res       (res),
    .out_stall (out_stall),
    .free      (buf_free),
    .out_valid (out_valid),
    .kind      (kind),
    .data      (out_byte),
    .last      (out_last)
  );

endmodule

### tb/scancode_set1_to_ascii_test.sv
// Self-checking testbench for the scancode set 1 translator, with its own key and state model.
module scancode_set1_to_ascii_test;
  import sc1a_pkg::kind_t;
  import sc1a_pkg::KIND_CHAR;
  import sc1a_pkg::KIND_LED;
  import sc1a_pkg::KIND_REBOOT;

  localparam int RANDOM_ITEMS = 140;
  localparam int STEADY_FROM  = 60;
  localparam int STEADY_TO    = 100;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  localparam logic [7:0] PREFIX_E0 = 8'he0;
  localparam logic [7:0] PREFIX_E1 = 8'he1;
  localparam logic [7:0] RELEASE   = 8'h80;

  localparam logic [1:0] AFTER_NONE = 2'd0;
  localparam logic [1:0] AFTER_E0   = 2'd1;
  localparam logic [1:0] AFTER_E1   = 2'd2;

  localparam logic [6:0] K_CTRL     = 7'h1d;
  localparam logic [6:0] K_ALT      = 7'h38;
  localparam logic [6:0] K_LSHIFT   = 7'h2a;
  localparam logic [6:0] K_RSHIFT   = 7'h36;
  localparam logic [6:0] K_CAPS     = 7'h3a;
  localparam logic [6:0] K_NUM      = 7'h45;
  localparam logic [6:0] K_SCROLL   = 7'h46;
  localparam logic [6:0] K_F1       = 7'h3b;
  localparam logic [6:0] K_F10      = 7'h44;
  localparam logic [6:0] K_SLASH    = 7'h35;
  localparam logic [6:0] K_PAD_STAR = 7'h37;
  localparam logic [6:0] K_PAD_HOME = 7'h47;
  localparam logic [6:0] K_PAD_DEL  = 7'h53;
  localparam logic [6:0] K_UNKNOWN  = 7'h54;

  localparam logic [2:0] LED_SCROLL = 3'b001;
  localparam logic [2:0] LED_NUM    = 3'b010;
  localparam logic [2:0] LED_CAPS   = 3'b100;

  localparam logic [7:0] ESC       = 8'h1b;
  localparam logic [7:0] LBRK      = 8'h5b;
  localparam logic [7:0] TILDE     = 8'h7e;
  localparam logic [7:0] DEL       = 8'h7f;
  localparam logic [7:0] CASE_GAP  = 8'h20;
  localparam logic [7:0] CTRL_GAP  = 8'h40;
  localparam logic [7:0] META      = 8'h80;

  localparam logic [7:0] PLAIN_KEYS [0:57] = '{
    8'h00, 8'h1b, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2d, 8'h3d, 8'h08, 8'h09,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6f, 8'h70, 8'h5b, 8'h5d, 8'h0a, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6a, 8'h6b, 8'h6c, 8'h3b,
    8'h27, 8'h60, 8'h00, 8'h5c, 8'h7a, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6e, 8'h6d, 8'h2c, 8'h2e, 8'h2f, 8'h00, 8'h2a,
    8'h00, 8'h20
  };

  localparam logic [7:0] SHIFT_KEYS [0:57] = '{
    8'h00, 8'h1b, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5e,
    8'h26, 8'h2a, 8'h28, 8'h29, 8'h5f, 8'h2b, 8'h08, 8'h09,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4f, 8'h50, 8'h7b, 8'h7d, 8'h0a, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4a, 8'h4b, 8'h4c, 8'h3a,
    8'h22, 8'h7e, 8'h00, 8'h7c, 8'h5a, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4e, 8'h4d, 8'h3c, 8'h3e, 8'h3f, 8'h00, 8'h2a,
    8'h00, 8'h20
  };

  // bit 7 selects the ESC [ x ~ form
  localparam logic [7:0] PAD_MOVES [0:12] = '{
    8'h48, 8'h41, 8'hb5, 8'h2d, 8'h44, 8'h35, 8'h43, 8'h2b,
    8'hb4, 8'h42, 8'hb6, 8'hb2, 8'h7f
  };

  localparam logic [7:0] PAD_DIGITS [0:12] = '{
    8'h37, 8'h38, 8'h39, 8'h2d, 8'h34, 8'h35, 8'h36, 8'h2b,
    8'h31, 8'h32, 8'h33, 8'h30, 8'h2e
  };

  localparam logic BY_MODEL = 1'b0;
  localparam logic TYPED    = 1'b1;

  typedef struct packed {
    logic [7:0] code;
    logic [2:0] room;
    logic       typed;
    logic       has_res;
    kind_t      kind;
    logic [7:0] data;
  } stim_row_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic       last;
  } key_res_t;

  localparam int OPENING_LEN = 32;
  localparam stim_row_t OPENING [0:OPENING_LEN-1] = '{
    '{8'h01, 3'd4, TYPED,    1'b1, KIND_CHAR,   8'h1b},
    '{8'h00, 3'd7, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'hff, 3'd0, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h1e, 3'd0, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h3a, 3'd1, TYPED,    1'b1, KIND_LED,    8'h04},
    '{8'h1e, 3'd4, BY_MODEL, 1'b0, KIND_CHAR,   8'h00},
    '{8'h46, 3'd0, TYPED,    1'b1, KIND_LED,    8'h05},
    '{8'h45, 3'd2, TYPED,    1'b1, KIND_LED,    8'h07},
    '{8'h47, 3'd4, BY_MODEL, 1'b0, KIND_CHAR,   8'h00},
    '{8'he0, 3'd6, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h48, 3'd3, BY_MODEL, 1'b0, KIND_CHAR,   8'h00},
    '{8'h3b, 3'd3, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h44, 3'd4, BY_MODEL, 1'b0, KIND_CHAR,   8'h00},
    '{8'he0, 3'd0, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h35, 3'd1, BY_MODEL, 1'b0, KIND_CHAR,   8'h00},
    '{8'h2a, 3'd4, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h49, 3'd4, BY_MODEL, 1'b0, KIND_CHAR,   8'h00},
    '{8'h1d, 3'd4, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h35, 3'd4, BY_MODEL, 1'b0, KIND_CHAR,   8'h00},
    '{8'he1, 3'd0, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h38, 3'd5, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h53, 3'd0, TYPED,    1'b1, KIND_REBOOT, 8'h00},
    '{8'h03, 3'd4, BY_MODEL, 1'b0, KIND_CHAR,   8'h00},
    '{8'h54, 3'd7, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h4c, 3'd4, BY_MODEL, 1'b0, KIND_CHAR,   8'h00},
    '{8'h37, 3'd4, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'he1, 3'd0, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'he0, 3'd0, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'hb8, 3'd4, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'h53, 3'd1, BY_MODEL, 1'b0, KIND_CHAR,   8'h00},
    '{8'he0, 3'd0, TYPED,    1'b0, KIND_CHAR,   8'h00},
    '{8'hb5, 3'd4, TYPED,    1'b0, KIND_CHAR,   8'h00}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_scan_code = 8'h00;
  logic [2:0] in_out_room = 3'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_kind;
  logic [7:0] out_byte;
  logic       out_last;

  logic       steady = 1'b0;
  stim_row_t  cur_row = '0;
  int         items_sent = 0;
  int         mismatches = 0;
  int         quiet_cycles = 0;

  logic [1:0] pending_prefix = AFTER_NONE;
  logic       lctrl_down = 1'b0, rctrl_down = 1'b0;
  logic       lshift_down = 1'b0, rshift_down = 1'b0;
  logic       lalt_down = 1'b0, ralt_down = 1'b0;
  logic [2:0] lock_flags = 3'b000;

  key_res_t   fresh_results [$];
  key_res_t   owed_results [$];

  scancode_set1_to_ascii dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_scan_code(in_scan_code),
    .in_out_room (in_out_room),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_kind    (out_kind),
    .out_byte    (out_byte),
    .out_last    (out_last)
  );

  always #5 clk = ~clk;

  task automatic emit_result(input kind_t kind, input logic [7:0] data);
    if (fresh_results.size() < 4) fresh_results.push_back(key_res_t'{kind, data, 1'b0});
  endtask

  task automatic translate_scancode(input logic [7:0] code, input logic [2:0] room);
    logic [6:0] bare;
    logic       press;
    logic       ctl;
    logic       shifted;
    logic       cursor;
    logic [7:0] c;
    bare = code[6:0];
    press = !code[7];
    ctl = lctrl_down || rctrl_down;
    shifted = lshift_down || rshift_down;
    fresh_results.delete();
    if (code == PREFIX_E0) begin
      pending_prefix = AFTER_E0;
    end else if (code == PREFIX_E1) begin
      pending_prefix = AFTER_E1;
    end else begin
      if (bare == K_CTRL) begin
        if (pending_prefix != AFTER_NONE) rctrl_down = press;
        else lctrl_down = press;
      end else if (bare == K_ALT) begin
        if (pending_prefix != AFTER_NONE) ralt_down = press;
        else lalt_down = press;
      end else if (bare == K_LSHIFT) begin
        lshift_down = press;
      end else if (bare == K_RSHIFT) begin
        rshift_down = press;
      end else if (press && bare < K_UNKNOWN) begin
        if (bare == K_CAPS || bare == K_NUM || bare == K_SCROLL) begin
          lock_flags = lock_flags ^ ((bare == K_CAPS) ? LED_CAPS :
                                     (bare == K_NUM) ? LED_NUM : LED_SCROLL);
          emit_result(KIND_LED, {5'd0, lock_flags});
        end else if (bare >= K_F1 && bare <= K_F10) begin
          if (room >= 4) begin
            emit_result(KIND_CHAR, ESC);
            emit_result(KIND_CHAR, LBRK);
            emit_result(KIND_CHAR, LBRK);
            emit_result(KIND_CHAR, 8'h41 + {1'b0, bare - K_F1});
          end
        end else if (bare == K_PAD_DEL && ctl && (lalt_down || ralt_down)) begin
          emit_result(KIND_REBOOT, 8'h00);
        end else if (bare == K_PAD_STAR || bare >= K_PAD_HOME) begin
          cursor = pending_prefix == AFTER_E0 || !lock_flags[1] || shifted;
          if (cursor && bare >= K_PAD_HOME) begin
            c = PAD_MOVES[bare - K_PAD_HOME];
            if (c[7]) begin
              if (room >= 4) begin
                emit_result(KIND_CHAR, ESC);
                emit_result(KIND_CHAR, LBRK);
                emit_result(KIND_CHAR, {1'b0, c[6:0]});
                emit_result(KIND_CHAR, TILDE);
              end
            end else if (c >= 8'h41 && c <= 8'h5a) begin
              if (room >= 3) begin
                emit_result(KIND_CHAR, ESC);
                emit_result(KIND_CHAR, LBRK);
                emit_result(KIND_CHAR, c);
              end
            end else if (room >= 1) begin
              emit_result(KIND_CHAR, c);
            end
          end else if (!cursor && room >= 1) begin
            emit_result(KIND_CHAR, (bare == K_PAD_STAR) ? 8'h2a : PAD_DIGITS[bare - K_PAD_HOME]);
          end
        end else if (bare == K_SLASH && pending_prefix == AFTER_E0) begin
          if (room >= 1) emit_result(KIND_CHAR, 8'h2f);
        end else if (room >= 1) begin
          if (ralt_down) begin
            case (bare)
              7'h03: c = 8'h40;
              7'h05: c = 8'h24;
              7'h08: c = 8'h7b;
              7'h09: c = 8'h5b;
              7'h0a: c = 8'h5d;
              7'h0b: c = 8'h7d;
              7'h0c: c = 8'h5c;
              7'h1b: c = 8'h7e;
              7'h1c: c = 8'h0d;
              default: c = 8'h00;
            endcase
          end else if (shifted) begin
            c = SHIFT_KEYS[bare];
          end else begin
            c = PLAIN_KEYS[bare];
          end
          if (c != 8'h00) begin
            if ((ralt_down || !shifted) && (lock_flags[2] || ctl) && c >= 8'h61 && c <= 8'h7a)
              c = c - CASE_GAP;
            if (ctl) begin
              if (c >= 8'h40 && c < 8'h60) c = c - CTRL_GAP;
              else if (c == 8'h3f) c = DEL;
            end
            if (lalt_down) c = c | META;
            emit_result(KIND_CHAR, c);
          end
        end
      end
      pending_prefix = AFTER_NONE;
      if (fresh_results.size() != 0) fresh_results[fresh_results.size() - 1].last = 1'b1;
    end
  endtask

  always @(posedge clk) begin
    key_res_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (owed_results.size() == 0) begin
          $error("out_byte: expected no transfer, actual %02h", out_byte);
          mismatches++;
        end else begin
          want = owed_results.pop_front();
          if (out_kind !== want.kind) begin
            $error("out_kind: expected %0d, actual %0d", want.kind, out_kind);
            mismatches++;
          end
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
            mismatches++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0b, actual %0b", want.last, out_last);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        translate_scancode(in_scan_code, in_out_room);
        if (cur_row.typed) begin
          fresh_results.delete();
          if (cur_row.has_res)
            fresh_results.push_back(key_res_t'{cur_row.kind, cur_row.data, 1'b1});
        end
        foreach (fresh_results[i]) owed_results.push_back(fresh_results[i]);
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("scancode_set1_to_ascii: mismatch");
          $finish;
        end
      end
    end
  end

  always @(negedge clk) out_stall <= !steady && ($urandom_range(0, 99) < 14);

  task automatic send_item(input stim_row_t row);
    while (!steady && $urandom_range(0, 99) < 14) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_scan_code = row.code;
    in_out_room = row.room;
    cur_row = row;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    items_sent++;
  endtask

  initial begin
    stim_row_t row;
    stim_row_t lead;
    int        pick;
    row = '0;
    lead = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < OPENING_LEN; i++) send_item(OPENING[i]);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      steady = items_sent >= STEADY_FROM && items_sent < STEADY_TO;
      pick = $urandom_range(0, 99);
      row = '0;
      row.typed = BY_MODEL;
      row.room = ($urandom_range(0, 9) < 7) ? 3'($urandom_range(4, 7)) : 3'($urandom_range(0, 3));
      lead = row;
      lead.code = PREFIX_E0;
      if (pick < 40) begin
        row.code = 8'($urandom_range(1, 8'h53));
      end else if (pick < 55) begin
        case ($urandom_range(0, 3))
          0: row.code = {1'b0, K_CTRL};
          1: row.code = {1'b0, K_ALT};
          2: row.code = {1'b0, K_LSHIFT};
          default: row.code = {1'b0, K_RSHIFT};
        endcase
        if ((row.code[6:0] == K_CTRL || row.code[6:0] == K_ALT) && $urandom_range(0, 1))
          send_item(lead);
        if ($urandom_range(0, 1)) row.code = row.code | RELEASE;
      end else if (pick < 67) begin
        case ($urandom_range(0, 9))
          0: row.code = {1'b0, K_SLASH};
          1: row.code = {1'b0, K_PAD_STAR};
          default: row.code = 8'($urandom_range(K_PAD_HOME, K_PAD_DEL));
        endcase
        if ($urandom_range(0, 4) == 0) row.code = row.code | RELEASE;
        send_item(lead);
      end else if (pick < 77) begin
        row.code = RELEASE | 8'($urandom_range(1, 8'h53));
      end else if (pick < 82) begin
        case ($urandom_range(0, 2))
          0: row.code = {1'b0, K_CAPS};
          1: row.code = {1'b0, K_NUM};
          default: row.code = {1'b0, K_SCROLL};
        endcase
      end else if (pick < 87) begin
        row.code = 8'($urandom_range(K_F1, K_F10));
      end else begin
        row.code = 8'($urandom_range(0, 255));
      end
      send_item(row);
    end
    steady = 1'b0;
    in_valid = 1'b0;

    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("scancode_set1_to_ascii: match");
    end else begin
      $display("scancode_set1_to_ascii: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
sv/sc1a_pkg.sv
sv/sc1a_xlate.sv
sv/sc1a_outbuf.sv
sv/scancode_set1_to_ascii.sv
tb/scancode_set1_to_ascii_test.sv
